>>> rtl/wsdf_pkg.sv
// wsdf_pkg: shared types and constants of the websocket frame deframer
// no dependencies; imported by wsdf_parser, websocket_frame_deframer, deframer_checker and the testbench
package wsdf_pkg;

	localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;

	localparam logic [3:0] OP_CONT  = 4'd0;
	localparam logic [3:0] OP_TEXT  = 4'd1;
	localparam logic [3:0] OP_BIN   = 4'd2;
	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;
	localparam logic [3:0] OP_PONG  = 4'd10;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_PROTO   = 2'd1;
	localparam logic [1:0] ERR_TOO_BIG = 2'd2;

	localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
	localparam logic [6:0] LEN7_EXT16    = 7'd126;
	localparam logic [6:0] LEN7_EXT64    = 7'd127;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXT16   = 6'b000100,
		PH_EXT64   = 6'b001000,
		PH_KEY     = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       peer_closing;
	} in_word_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic       frame_end;
		logic       message_end;
		logic [1:0] error_code;
	} out_word_t;

	function automatic logic is_control(input logic [3:0] op);
		return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
	endfunction

endpackage

>>> rtl/websocket_frame_deframer.sv
// websocket_frame_deframer: top level, input register, result register, limit register
// depends on wsdf_pkg and wsdf_parser
//
// Usage: client bytes enter on the in channel (in_valid / in_stall, word in_data
// carrying rx_byte and peer_closing), one word per cycle if not stalled. Results
// leave on the out channel (out_valid / out_stall, word out_data). Only payload
// bytes, the end of a zero-length frame and an error produce a result word; header,
// length and most key bytes are absorbed. The cfg channel (cfg_valid / cfg_ready,
// always ready) writes max_message_length; write it only while the block is idle.
// Order: an accepted word is held in the input register and parsed from there;
// its result is registered in the result register, visible from then on.
// Throughput: one byte per cycle while no stall holds it, set by the single parse
// step between the input register and the result register.
// Stall: while out_stall holds a waiting result, a byte needing a result waits
// in the input register and in_stall rises; bytes without a result still pass.
// Reset: parse state returns to the first header byte, the limit to 16777216,
// and sticky error / close-done state is cleared.
module websocket_frame_deframer import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic        valid_s1;
	in_word_t    word_s1;
	logic        out_valid_q;
	out_word_t   out_word_q;
	logic [31:0] max_len_q;
	logic        res_valid;
	out_word_t   res;
	logic        out_free;
	logic        proceed;
	logic        accept_in;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign proceed   = valid_s1 && (!res_valid || out_free);
	assign in_stall  = valid_s1 && !proceed;
	assign accept_in = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	wsdf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (proceed),
		.word      (word_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			max_len_q   <= MAX_LEN_RESET;
		end else begin
			valid_s1 <= accept_in || (valid_s1 && !proceed);
			if (proceed && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			word_s1 <= in_data;
		end
		if (proceed && res_valid) begin
			out_word_q <= res;
		end
	end

endmodule

>>> rtl/wsdf_parser.sv
// wsdf_parser: frame parse state and per-byte next-state / result logic
// depends on wsdf_pkg
module wsdf_parser import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_word_t    word,
	input  logic [31:0] max_len,
	output logic        res_valid,
	output out_word_t   res
);

	phase_t      ph_q, ph_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        fin_q, fin_d;
	logic [3:0]  op_q, op_d;
	logic [1:0]  mtype_q, mtype_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] mask_q, mask_d;
	logic [1:0]  kidx_q, kidx_d;
	logic [31:0] msize_q, msize_d;
	logic        stop_q, stop_d;

	logic [7:0]  b;
	logic [3:0]  hop;
	logic        ctl;
	logic [63:0] len_now;
	logic [32:0] total;
	logic        too_big;
	logic [7:0]  key_byte;
	logic [7:0]  unmasked;
	logic [3:0]  res_op;
	logic        last_ext;

	assign b   = word.rx_byte;
	assign hop = b[3:0];
	assign ctl = is_control(op_q);

	// length as it stands once this byte is folded in
	assign len_now = (ph_q == PH_HDR1) ? {57'd0, b[6:0]} : {rem_q[55:0], b};
	assign total   = {1'b0, msize_q} + {1'b0, len_now[31:0]};
	always_comb begin
		if (ctl) begin
			too_big = (len_now[63:32] != 32'd0) || (len_now[31:0] > max_len);
		end else begin
			too_big = (len_now[63:32] != 32'd0) || (total > {1'b0, max_len});
		end
	end

	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = mask_q[31:24];
			2'd1:    key_byte = mask_q[23:16];
			2'd2:    key_byte = mask_q[15:8];
			default: key_byte = mask_q[7:0];
		endcase
	end
	assign unmasked = b ^ key_byte;
	assign res_op   = ctl ? op_q : {2'b00, mtype_q};
	assign last_ext = (ph_q == PH_EXT16) ? (cnt_q >= 3'd1) : (cnt_q >= 3'd7);

	always_comb begin
		ph_d      = ph_q;
		cnt_d     = cnt_q;
		fin_d     = fin_q;
		op_d      = op_q;
		mtype_d   = mtype_q;
		rem_d     = rem_q;
		mask_d    = mask_q;
		kidx_d    = kidx_q;
		msize_d   = msize_q;
		stop_d    = stop_q;
		res_valid = 1'b0;
		res       = '0;
		if (!stop_q) begin
			case (ph_q)
				PH_HDR0: begin
					if ((b[6:4] != 3'd0)
						|| (mtype_q == 2'd0 && hop == OP_CONT)
						|| (mtype_q != 2'd0 && (hop == OP_TEXT || hop == OP_BIN))
						|| (hop > OP_BIN && !is_control(hop))
						|| (word.peer_closing && hop != OP_CLOSE)) begin
						res_valid      = 1'b1;
						res.error_code = ERR_PROTO;
						stop_d         = 1'b1;
					end else begin
						fin_d = b[7];
						op_d  = hop;
						if (hop == OP_TEXT || hop == OP_BIN) begin
							mtype_d = hop[1:0];
						end
						ph_d = PH_HDR1;
					end
				end
				PH_HDR1, PH_EXT16, PH_EXT64: begin
					if (ph_q == PH_HDR1 && ctl && (!fin_q || b[6:0] > LEN7_CTRL_MAX)) begin
						res_valid      = 1'b1;
						res.error_code = ERR_PROTO;
						stop_d         = 1'b1;
					end else if (ph_q == PH_HDR1 && b[6:0] == LEN7_EXT16) begin
						rem_d = 64'd0;
						cnt_d = 3'd0;
						ph_d  = PH_EXT16;
					end else if (ph_q == PH_HDR1 && b[6:0] == LEN7_EXT64) begin
						rem_d = 64'd0;
						cnt_d = 3'd0;
						ph_d  = PH_EXT64;
					end else if (ph_q != PH_HDR1 && !last_ext) begin
						rem_d = len_now;
						cnt_d = cnt_q + 3'd1;
					end else begin
						// length complete: size check, then key bytes
						rem_d = len_now;
						cnt_d = 3'd0;
						if (too_big) begin
							res_valid      = 1'b1;
							res.error_code = ERR_TOO_BIG;
							stop_d         = 1'b1;
						end else begin
							if (!ctl) begin
								msize_d = total[31:0];
							end
							ph_d   = PH_KEY;
							kidx_d = 2'd0;
						end
					end
				end
				PH_KEY: begin
					case (kidx_q)
						2'd0:    mask_d[31:24] = b;
						2'd1:    mask_d[23:16] = b;
						2'd2:    mask_d[15:8]  = b;
						default: mask_d[7:0]   = b;
					endcase
					if (kidx_q != 2'd3) begin
						kidx_d = kidx_q + 2'd1;
					end else begin
						kidx_d = 2'd0;
						if (rem_q == 64'd0) begin
							res_valid        = 1'b1;
							res.frame_opcode = res_op;
							res.frame_end    = 1'b1;
							ph_d             = PH_HDR0;
							if (op_q == OP_CLOSE) begin
								res.message_end = 1'b1;
								stop_d          = 1'b1;
							end else if (!ctl && fin_q) begin
								res.message_end = 1'b1;
								mtype_d         = 2'd0;
								msize_d         = 32'd0;
							end
						end else begin
							ph_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					res_valid        = 1'b1;
					res.has_byte     = 1'b1;
					res.payload_byte = unmasked;
					res.frame_opcode = res_op;
					kidx_d           = kidx_q + 2'd1;
					rem_d            = rem_q - 64'd1;
					if (rem_q == 64'd1) begin
						res.frame_end = 1'b1;
						ph_d          = PH_HDR0;
						kidx_d        = 2'd0;
						if (op_q == OP_CLOSE) begin
							res.message_end = 1'b1;
							stop_d          = 1'b1;
						end else if (!ctl && fin_q) begin
							res.message_end = 1'b1;
							mtype_d         = 2'd0;
							msize_d         = 32'd0;
						end
					end
				end
				default: begin
					ph_d = PH_HDR0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_HDR0;
			cnt_q   <= 3'd0;
			fin_q   <= 1'b0;
			op_q    <= OP_CONT;
			mtype_q <= 2'd0;
			rem_q   <= 64'd0;
			mask_q  <= 32'd0;
			kidx_q  <= 2'd0;
			msize_q <= 32'd0;
			stop_q  <= 1'b0;
		end else if (step) begin
			ph_q    <= ph_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			op_q    <= op_d;
			mtype_q <= mtype_d;
			rem_q   <= rem_d;
			mask_q  <= mask_d;
			kidx_q  <= kidx_d;
			msize_q <= msize_d;
			stop_q  <= stop_d;
		end
	end

endmodule

>>> tb/deframer_checker.sv
// deframer_checker: watches the byte, result and limit channels of the deframer,
// predicts every result word from the accepted bytes and compares; uses wsdf_pkg
module deframer_checker import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_word_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          failures,
	output int          outstanding
);

	logic [31:0] limit;
	phase_t      phase;
	logic [2:0]  ext_count;
	logic        fin;
	logic [3:0]  opcode;
	logic [3:0]  msg_type;    // OP_CONT while no data message is open
	logic [63:0] remaining;
	logic [31:0] key;
	logic [1:0]  key_pos;
	logic [31:0] msg_bytes;
	logic        halted;
	out_word_t   expected_words[$];

	function automatic void check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
		end
	endfunction

	function automatic void stop_with(input logic [1:0] code);
		out_word_t w;
		w = '0;
		w.error_code = code;
		expected_words.push_back(w);
		halted = 1'b1;
	endfunction

	// valid opcodes with bit 3 set are exactly the control frames
	function automatic logic [3:0] tag_op();
		return opcode[3] ? opcode : msg_type;
	endfunction

	function automatic void length_complete();
		logic [63:0] total;
		if (opcode[3]) begin
			if (remaining > {32'd0, limit}) begin
				stop_with(ERR_TOO_BIG);
				return;
			end
		end else begin
			total = {32'd0, msg_bytes} + remaining;
			if (remaining[63:32] != 32'd0 || total > {32'd0, limit}) begin
				stop_with(ERR_TOO_BIG);
				return;
			end
			msg_bytes = total[31:0];
		end
		phase = PH_KEY;
		key_pos = 2'd0;
	endfunction

	function automatic void frame_complete(input logic has, input logic [7:0] b);
		out_word_t w;
		w = '0;
		w.has_byte = has;
		w.payload_byte = b;
		w.frame_opcode = tag_op();
		w.frame_end = 1'b1;
		if (opcode == OP_CLOSE) begin
			w.message_end = 1'b1;
			halted = 1'b1;
		end else if (!opcode[3] && fin) begin
			w.message_end = 1'b1;
			msg_type = OP_CONT;
			msg_bytes = 32'd0;
		end
		expected_words.push_back(w);
		phase = PH_HDR0;
		key_pos = 2'd0;
	endfunction

	function automatic void parse_byte(input in_word_t w);
		logic [7:0] b;
		logic [3:0] op;
		logic [6:0] len7;
		logic [7:0] v;
		out_word_t  r;
		b = w.rx_byte;
		op = b[3:0];
		len7 = b[6:0];
		if (halted)
			return;
		case (phase)
			PH_HDR0: begin
				if (b[6:4] != 3'd0)
					stop_with(ERR_PROTO);
				else if (msg_type == OP_CONT && op == OP_CONT)
					stop_with(ERR_PROTO);
				else if (msg_type != OP_CONT && (op == OP_TEXT || op == OP_BIN))
					stop_with(ERR_PROTO);
				else if (op > OP_BIN && !(op inside {OP_CLOSE, OP_PING, OP_PONG}))
					stop_with(ERR_PROTO);
				else if (w.peer_closing && op != OP_CLOSE)
					stop_with(ERR_PROTO);
				else begin
					fin = b[7];
					opcode = op;
					if (op == OP_TEXT || op == OP_BIN)
						msg_type = op;
					phase = PH_HDR1;
				end
			end
			PH_HDR1: begin
				if (opcode[3] && (!fin || len7 > LEN7_CTRL_MAX))
					stop_with(ERR_PROTO);
				else begin
					remaining = 64'd0;
					ext_count = 3'd0;
					if (len7 == LEN7_EXT16)
						phase = PH_EXT16;
					else if (len7 == LEN7_EXT64)
						phase = PH_EXT64;
					else begin
						remaining = {57'd0, len7};
						length_complete();
					end
				end
			end
			PH_EXT16, PH_EXT64: begin
				remaining = {remaining[55:0], b};
				if (ext_count >= ((phase == PH_EXT16) ? 3'd1 : 3'd7)) begin
					ext_count = 3'd0;
					length_complete();
				end else
					ext_count = ext_count + 3'd1;
			end
			PH_KEY: begin
				key[8 * (3 - key_pos) +: 8] = b;
				if (key_pos < 2'd3)
					key_pos = key_pos + 2'd1;
				else begin
					key_pos = 2'd0;
					if (remaining == 64'd0)
						frame_complete(1'b0, 8'd0);
					else
						phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				v = b ^ key[8 * (3 - key_pos) +: 8];
				key_pos = key_pos + 2'd1;
				if (remaining != 64'd0)
					remaining = remaining - 64'd1;
				if (remaining == 64'd0)
					frame_complete(1'b1, v);
				else begin
					r = '0;
					r.has_byte = 1'b1;
					r.payload_byte = v;
					r.frame_opcode = tag_op();
					expected_words.push_back(r);
				end
			end
			default: phase = PH_HDR0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			limit = MAX_LEN_RESET;
			phase = PH_HDR0;
			ext_count = 3'd0;
			fin = 1'b0;
			opcode = OP_CONT;
			msg_type = OP_CONT;
			remaining = 64'd0;
			key = 32'd0;
			key_pos = 2'd0;
			msg_bytes = 32'd0;
			halted = 1'b0;
			expected_words.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					failures++;
					$display("%0t: no result expected, got %h", $time, out_data);
				end else begin
					want = expected_words.pop_front();
					check_field("has_byte", 8'(want.has_byte), 8'(out_data.has_byte));
					check_field("payload_byte", want.payload_byte, out_data.payload_byte);
					check_field("frame_opcode", 8'(want.frame_opcode),
						8'(out_data.frame_opcode));
					check_field("frame_end", 8'(want.frame_end), 8'(out_data.frame_end));
					check_field("message_end", 8'(want.message_end),
						8'(out_data.message_end));
					check_field("error_code", 8'(want.error_code), 8'(out_data.error_code));
				end
			end
			if (cfg_valid && cfg_ready)
				limit = cfg_data;
			if (in_valid && !in_stall)
				parse_byte(in_data);
			outstanding = expected_words.size();
		end
	end

endmodule

>>> tb/tb_websocket_frame_deframer.sv
// tb_websocket_frame_deframer: drives framed client bytes and limit writes into the
// deframer with random gaps and stalls; depends on wsdf_pkg, deframer_checker and websocket_frame_deframer
module tb_websocket_frame_deframer;
	import wsdf_pkg::*;

	localparam int WORD_TARGET = 1400;

	typedef enum int {
		LEN_AUTO,
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_enc_t;

	typedef enum int {
		STOP_RSV,
		STOP_LONE_CONT,
		STOP_DATA_IN_MSG,
		STOP_BAD_OP,
		STOP_NOT_CLOSE,
		STOP_CTRL_FRAG,
		STOP_CTRL_LEN7,
		STOP_HUGE_EXT64,
		STOP_DATA_OVER,
		STOP_CTRL_OVER,
		STOP_CLOSE
	} stop_case_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	int          failures;
	int          outstanding;

	int          words_sent;
	int          results_seen;
	logic [31:0] max_len;       // limit currently programmed, shapes the frame lengths
	bit          gaps_on;
	stop_case_t  stop_case;

	websocket_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	deframer_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("tb_websocket_frame_deframer failed");
		$finish;
	end

	// result side: random stall before each word
	initial begin
		int n;
		out_stall = 1'b0;
		results_seen = 0;
		forever begin
			@(negedge clk);
			n = gaps_on ? $urandom_range(0, 8) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			results_seen++;
		end
	end

	// entered and left at a falling edge; valid stays high for a back-to-back word
	task automatic put_byte(input logic [7:0] b, input logic closing);
		int gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= in_word_t'{rx_byte: b, peer_closing: closing};
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic put_body(input logic [7:0] b);
		put_byte(b, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_frame(input logic [3:0] op, input logic fin, input int len,
			input logic closing, input len_enc_t enc);
		logic       m;
		len_enc_t   e;
		logic [63:0] len64;
		m = 1'($urandom_range(0, 1));
		len64 = 64'(len);
		e = enc;
		if (e == LEN_AUTO) begin
			if (op[3])
				e = LEN_SHORT;
			else if (len > 125)
				e = $urandom_range(0, 1) ? LEN_EXT16 : LEN_EXT64;
			else
				case ($urandom_range(0, 5))
					4: e = LEN_EXT16;
					5: e = LEN_EXT64;
					default: e = LEN_SHORT;
				endcase
		end
		put_byte({fin, 3'b000, op}, closing);
		case (e)
			LEN_EXT16: begin
				put_body({m, LEN7_EXT16});
				for (int i = 1; i >= 0; i--)
					put_body(len64[8 * i +: 8]);
			end
			LEN_EXT64: begin
				put_body({m, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					put_body(len64[8 * i +: 8]);
			end
			default: put_body({m, len64[6:0]});
		endcase
		repeat (4) put_body(8'($urandom_range(0, 255)));
		repeat (len) put_body(8'($urandom_range(0, 255)));
	endtask

	function automatic int pick_len(input longint cap);
		longint hi;
		hi = ($urandom_range(0, 19) == 0) ? 300 : 12;
		if (cap < hi)
			hi = cap;
		return $urandom_range(0, int'(hi));
	endfunction

	task automatic send_control();
		longint cap;
		cap = max_len;
		if (cap > 125)
			cap = 125;
		send_frame($urandom_range(0, 1) ? OP_PING : OP_PONG, 1'b1, pick_len(cap), 1'b0,
			LEN_AUTO);
	endtask

	// one data message in fragments, control frames may sit between them
	task automatic send_message();
		logic [3:0] kind;
		int         frags;
		int         len;
		longint     total;
		kind = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
		frags = $urandom_range(1, 4);
		total = 0;
		gaps_on = ($urandom_range(0, 4) != 0);
		for (int f = 0; f < frags; f++) begin
			if (f > 0 && $urandom_range(0, 2) == 0)
				send_control();
			len = pick_len(longint'(max_len) - total);
			send_frame((f == 0) ? kind : OP_CONT, f == frags - 1, len, 1'b0, LEN_AUTO);
			total += len;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		max_len = v;
	endtask

	task automatic run_traffic(input int upto);
		while (words_sent < upto) begin
			if ($urandom_range(0, 3) == 0)
				send_control();
			send_message();
		end
	endtask

	// the block stays stopped until reset, so only one such case ends each run
	task automatic send_stop_case();
		logic [3:0] op;
		case (stop_case)
			STOP_RSV:
				put_byte({1'b1, 3'($urandom_range(1, 7)), OP_TEXT}, 1'b0);
			STOP_LONE_CONT:
				put_byte({1'($urandom_range(0, 1)), 3'b000, OP_CONT}, 1'b0);
			STOP_DATA_IN_MSG: begin
				send_frame(OP_TEXT, 1'b0, pick_len(1), 1'b0, LEN_AUTO);
				op = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
				put_byte({1'($urandom_range(0, 1)), 3'b000, op}, 1'b0);
			end
			STOP_BAD_OP: begin
				op = 4'($urandom_range(3, 7));
				if ($urandom_range(0, 1))
					op = op + 4'd8;
				put_byte({1'b1, 3'b000, op}, 1'b0);
			end
			STOP_NOT_CLOSE: begin
				case ($urandom_range(0, 3))
					0: op = OP_TEXT;
					1: op = OP_BIN;
					2: op = OP_PING;
					default: op = OP_PONG;
				endcase
				put_byte({1'b1, 3'b000, op}, 1'b1);
			end
			STOP_CTRL_FRAG: begin
				put_byte({1'b0, 3'b000, $urandom_range(0, 1) ? OP_PING : OP_CLOSE}, 1'b0);
				put_body(8'($urandom_range(0, 5)));
			end
			STOP_CTRL_LEN7: begin
				put_byte({1'b1, 3'b000, OP_PONG}, 1'b0);
				put_body({1'($urandom_range(0, 1)), 7'($urandom_range(126, 127))});
			end
			STOP_HUGE_EXT64: begin
				put_byte({1'b1, 3'b000, OP_BIN}, 1'b0);
				put_body({1'b1, LEN7_EXT64});
				put_body(8'($urandom_range(1, 255)));
				repeat (7) put_body(8'($urandom_range(0, 255)));
			end
			STOP_DATA_OVER:
				send_frame(OP_BIN, 1'($urandom_range(0, 1)), max_len + $urandom_range(1, 3),
					1'b0, LEN_AUTO);
			STOP_CTRL_OVER: begin
				if (max_len < 125)
					send_frame(OP_PING, 1'b1, $urandom_range(max_len + 1, 125), 1'b0,
						LEN_AUTO);
				else
					send_frame(OP_CLOSE, 1'b1, 0, 1'b1, LEN_AUTO);
			end
			default:
				send_frame(OP_CLOSE, 1'b1, pick_len(max_len < 125 ? max_len : 125),
					1'($urandom_range(0, 1)), LEN_AUTO);
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		words_sent = 0;
		max_len = MAX_LEN_RESET;
		gaps_on = 1'b1;
		stop_case = stop_case_t'($urandom_range(0, 10));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty text frame, fragment across a ping, 16-bit length on a continuation
		send_frame(OP_TEXT, 1'b1, 0, 1'b0, LEN_SHORT);
		send_frame(OP_BIN, 1'b0, 1, 1'b0, LEN_SHORT);
		send_frame(OP_PING, 1'b1, 0, 1'b0, LEN_SHORT);
		send_frame(OP_CONT, 1'b1, 2, 1'b0, LEN_EXT16);

		run_traffic(WORD_TARGET / 4);
		set_limit(32'($urandom_range(40, 400)));
		run_traffic(WORD_TARGET / 2);
		set_limit(32'hFFFF_FFFF);
		run_traffic(3 * WORD_TARGET / 4);
		set_limit(32'd1);
		run_traffic(WORD_TARGET);
		set_limit(32'($urandom_range(1, 300)));
		send_message();
		gaps_on = 1'b1;
		send_stop_case();
		// after the stop nothing may come out
		repeat (16) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		drain();
		repeat (8) @(negedge clk);

		$display("sent %0d byte words and took %0d result words across five limit settings",
			words_sent, results_seen);
		$display("run ended on stop case %s with final limit %0d", stop_case.name(), max_len);
		if (failures == 0 && outstanding == 0)
			$display("tb_websocket_frame_deframer passed");
		else
			$display("tb_websocket_frame_deframer failed");
		$finish;
	end

endmodule
